/* rtl/core/odo_pkg.sv */
`default_nettype none
package odo_pkg;

  // serial multiplier operand widths
  localparam int MW  = 34;
  localparam int QW  = 32;
  localparam int PW  = MW + QW;
  localparam int QCW = $clog2(QW);

  // scale factors, Q0.32
  localparam logic [31:0] MM_PER_COUNT = 32'd332714064;
  localparam logic [31:0] RAD_PER_DEG  = 32'd74961321;

  // CORDIC gain in Q2.30 and step count
  localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
  localparam int CORDIC_STEPS = 20;
  localparam int CSW = $clog2(CORDIC_STEPS);

  // angles in Q16.16 degrees
  localparam logic [24:0] FULL_TURN    = 25'd23592960;
  localparam logic [24:0] HALF_TURN    = 25'd11796480;
  localparam logic [24:0] QUARTER_TURN = 25'd5898240;
  // 92 full turns, lifts any angle of magnitude up to 2^31 above zero
  localparam logic [33:0] TURN_BIAS    = 34'd2170552320;
  localparam int MOD_STEPS = 9;
  localparam int MSW = $clog2(MOD_STEPS);

  // status of a multi-cycle unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [21:0] atan_step(input logic [CSW-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/odo_mul.sv */
`default_nettype none
module odo_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [odo_pkg::MW-1:0]   mcand,
  input  logic [odo_pkg::QW-1:0]   mplier,
  output logic [odo_pkg::PW-1:0]   prod,
  output odo_pkg::unit_stat_t      stat
);
  import odo_pkg::*;

  logic [MW-1:0]  m;
  logic [MW-1:0]  hi;
  logic [QW-1:0]  lo;
  logic [QCW-1:0] cnt;
  logic           busy;
  logic           done;
  logic [MW:0]    sum;

  // one multiplier bit per cycle, LSB first
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, m} : '0);
  assign prod = {hi, lo};
  assign stat = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == QCW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial product shift register
  always_ff @(posedge clk) begin
    if (start) begin
      m  <= mcand;
      hi <= '0;
      lo <= mplier;
    end else if (busy) begin
      hi <= sum[MW:1];
      lo <= {sum[0], lo[QW-1:1]};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/odo_modr.sv */
`default_nettype none
module odo_modr (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] val,
  output logic [24:0]        rem,
  output odo_pkg::unit_stat_t stat
);
  import odo_pkg::*;

  logic [33:0]    u;
  logic [MSW-1:0] k;
  logic           busy;
  logic           done;
  logic [33:0]    sub;

  // restoring reduction by full turns, one quotient bit per cycle
  assign sub  = {9'b0, FULL_TURN} << k;
  assign rem  = u[24:0];
  assign stat = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= MSW'(MOD_STEPS - 1);
      end else if (busy) begin
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u <= {val[32], val} + TURN_BIAS;
    end else if (busy && (u >= sub)) begin
      u <= u - sub;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/odo_cordic.sv */
`default_nettype none
module odo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [24:0]        angle,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o,
  output odo_pkg::unit_stat_t stat
);
  import odo_pkg::*;

  localparam logic signed [25:0] FULL_S = {1'b0, FULL_TURN};
  localparam logic signed [25:0] HALF_S = {1'b0, HALF_TURN};
  localparam logic signed [25:0] QTR_S  = {1'b0, QUARTER_TURN};

  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [25:0] z;
  logic               neg;
  logic [CSW-1:0]     i;
  logic               busy;
  logic               done;
  logic signed [25:0] za;
  logic signed [25:0] zf;
  logic               negf;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [25:0] at;

  // fold [0,360) into [-90,90], remember the half-turn flip
  always_comb begin
    za = {1'b0, angle};
    if (za > HALF_S) za = za - FULL_S;
    zf   = za;
    negf = 1'b0;
    if (za > QTR_S) begin
      zf   = za - HALF_S;
      negf = 1'b1;
    end else if (za < -QTR_S) begin
      zf   = za + HALF_S;
      negf = 1'b1;
    end
  end

  assign xs = y >>> i;
  assign ys = x >>> i;
  assign at = {4'b0, atan_step(i)};

  assign cos_o = neg ? -x : x;
  assign sin_o = neg ? -y : y;
  assign stat  = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 1'b1;
        if (i == CSW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one rotation step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x   <= CORDIC_K;
      y   <= '0;
      z   <= zf;
      neg <= negf;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - xs;
        y <= y + ys;
        z <= z - at;
      end else begin
        x <= x + xs;
        y <= y - ys;
        z <= z + at;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/two_wheel_odometry_tracker_unit.sv */
// Two tracking wheel odometry tracker.
// Input channel (in_valid/in_ready): one request per sample period with the
// raw X and Y encoder counts and the gyro heading. Output channel
// (out_valid/out_ready): pos_x, pos_y and display_angle after that sample.
// Configuration: APB write/read of invert, lever arm and gain registers at
// byte addresses 0,4,..,20; pready is tied high. Write only while idle.
// Sequence: eleven products go through one bit-serial 34x32 multiplier in
// turn; range reduction and a 20-step CORDIC for sin/cos run beside the
// first products, and the display angle reduction and accumulator update
// follow. A new sample is taken only after the last one is through;
// in_ready is high only while no sample is in work.
// A finished result sits in the output register; a new request is taken
// while it waits, and the next result waits in the final state until the
// receiver takes the current one.
// Reset (synchronous, rst high) clears both accumulators and the stored
// headings and loads the register defaults; no clearing pass is needed.
`default_nettype none
module two_wheel_odometry_tracker_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        count_x,
  input  logic [15:0]        count_y,
  input  logic signed [31:0] gyro_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [24:0] display_angle,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import odo_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LAUNCH = 7'b0000010,
    S_MULW   = 7'b0000100,
    S_RND    = 7'b0001000,
    S_ACC    = 7'b0010000,
    S_DISPW  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    OP_TX, OP_WX, OP_TY, OP_WY, OP_DT, OP_LA, OP_LB,
    OP_AC, OP_BS, OP_BC, OP_AS
  } op_t;

  typedef enum logic [2:0] {
    REG_INVERT_X  = 3'd0,
    REG_INVERT_Y  = 3'd1,
    REG_OFFSET_LX = 3'd2,
    REG_OFFSET_LY = 3'd3,
    REG_GAIN_X    = 3'd4,
    REG_GAIN_Y    = 3'd5
  } reg_idx_t;

  localparam logic signed [32:0] HALF33 = {8'b0, HALF_TURN};
  localparam logic signed [25:0] FULL_S = {1'b0, FULL_TURN};
  localparam logic [15:0] NEG_COUNT = 16'd30000;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -49'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sd140737488355327)       r = 48'sh7FFFFFFFFFFF;
    else if (v < -50'sd140737488355328) r = 48'sh800000000000;
    else                                r = v[47:0];
    return r;
  endfunction

  // configuration registers
  logic               invert_x;
  logic               invert_y;
  logic signed [31:0] offset_lx;
  logic signed [31:0] offset_ly;
  logic [17:0]        gain_x;
  logic [17:0]        gain_y;

  // control
  state_t state;
  op_t    op;
  logic   mod_disp;
  logic   cordic_ok;

  // sample and intermediate values
  logic [15:0]        cx_mag;
  logic [15:0]        cy_mag;
  logic               cx_neg;
  logic               cy_neg;
  logic signed [31:0] g_q;
  logic [32:0]        dh_mag;
  logic               dh_neg;
  logic [33:0]        tprod;
  logic signed [31:0] wx;
  logic signed [31:0] wy;
  logic signed [31:0] dth;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic signed [63:0] sumx;
  logic signed [63:0] sumy;
  logic [63:0]        magx;
  logic [63:0]        magy;
  logic               negx;
  logic               negy;
  logic signed [24:0] disp_q;

  // architectural state
  logic signed [47:0] acc_x;
  logic signed [47:0] acc_y;
  logic signed [31:0] heading_now;
  logic signed [31:0] heading_prev;

  // unit hookups
  logic               in_acc;
  logic               mul_start;
  logic [MW-1:0]      mcand;
  logic [QW-1:0]      mplier;
  logic               mul_sgn;
  logic [PW-1:0]      mul_prod;
  unit_stat_t         mul_st;
  logic               mod_start;
  logic signed [32:0] mod_val;
  logic [24:0]        mod_rem;
  unit_stat_t         mod_st;
  logic               cor_start;
  logic signed [32:0] cos_v;
  logic signed [32:0] sin_v;
  unit_stat_t         cor_st;

  logic               wr;
  logic [32:0]        dh;
  logic signed [32:0] ng;
  logic [31:0]        cos_mag;
  logic [31:0]        sin_mag;
  logic [63:0]        p64;
  logic signed [63:0] p_s;
  logic [64:0]        rsum32;
  logic [64:0]        rsum16;
  logic [31:0]        rnd32;
  logic signed [48:0] r16_49;
  logic signed [48:0] wx49;
  logic signed [48:0] wy49;
  logic [64:0]        rsumx;
  logic [64:0]        rsumy;
  logic signed [49:0] rx50;
  logic signed [49:0] ry50;
  logic signed [49:0] ax50;
  logic signed [49:0] ay50;
  logic signed [25:0] rem_s;
  logic signed [24:0] disp_next;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;

  // APB register file
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_x  <= 1'b0;
      invert_y  <= 1'b0;
      offset_lx <= 32'sd5439488;
      offset_ly <= 32'sd21299200;
      gain_x    <= 18'd69247;
      gain_y    <= 18'd68012;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_INVERT_X:  invert_x  <= pwdata[0];
        REG_INVERT_Y:  invert_y  <= pwdata[0];
        REG_OFFSET_LX: offset_lx <= pwdata;
        REG_OFFSET_LY: offset_ly <= pwdata;
        REG_GAIN_X:    gain_x    <= pwdata[17:0];
        REG_GAIN_Y:    gain_y    <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_INVERT_X:  prdata = {31'b0, invert_x};
      REG_INVERT_Y:  prdata = {31'b0, invert_y};
      REG_OFFSET_LX: prdata = offset_lx;
      REG_OFFSET_LY: prdata = offset_ly;
      REG_GAIN_X:    prdata = {14'b0, gain_x};
      REG_GAIN_Y:    prdata = {14'b0, gain_y};
      default:       prdata = '0;
    endcase
  end

  // heading change and negated gyro heading
  assign dh = {heading_now[31], heading_now} - {heading_prev[31], heading_prev};
  assign ng = -{g_q[31], g_q};

  assign cos_mag = cos_v[32] ? 32'(-cos_v) : cos_v[31:0];
  assign sin_mag = sin_v[32] ? 32'(-sin_v) : sin_v[31:0];

  // multiplier operand select, sign carried aside
  always_comb begin
    mcand   = '0;
    mplier  = '0;
    mul_sgn = 1'b0;
    case (op)
      OP_TX: begin
        mcand  = {16'b0, gain_x};
        mplier = {16'b0, cx_mag};
      end
      OP_WX: begin
        mcand   = tprod;
        mplier  = MM_PER_COUNT;
        mul_sgn = cx_neg ^ invert_x;
      end
      OP_TY: begin
        mcand  = {16'b0, gain_y};
        mplier = {16'b0, cy_mag};
      end
      OP_WY: begin
        mcand   = tprod;
        mplier  = MM_PER_COUNT;
        mul_sgn = cy_neg ^ invert_y;
      end
      OP_DT: begin
        mcand   = {1'b0, dh_mag};
        mplier  = RAD_PER_DEG;
        mul_sgn = dh_neg;
      end
      OP_LA: begin
        mcand   = {2'b0, abs32(offset_lx)};
        mplier  = abs32(dth);
        mul_sgn = offset_lx[31] ^ dth[31];
      end
      OP_LB: begin
        mcand   = {2'b0, abs32(offset_ly)};
        mplier  = abs32(dth);
        mul_sgn = offset_ly[31] ^ dth[31];
      end
      OP_AC: begin
        mcand   = {2'b0, abs32(a_q)};
        mplier  = cos_mag;
        mul_sgn = a_q[31] ^ cos_v[32];
      end
      OP_BS: begin
        mcand   = {2'b0, abs32(b_q)};
        mplier  = sin_mag;
        mul_sgn = b_q[31] ^ sin_v[32];
      end
      OP_BC: begin
        mcand   = {2'b0, abs32(b_q)};
        mplier  = cos_mag;
        mul_sgn = b_q[31] ^ cos_v[32];
      end
      OP_AS: begin
        mcand   = {2'b0, abs32(a_q)};
        mplier  = sin_mag;
        mul_sgn = a_q[31] ^ sin_v[32];
      end
      default: ;
    endcase
  end

  // product rounding, half away from zero on magnitudes
  assign p64    = mul_prod[63:0];
  assign p_s    = p64;
  assign rsum32 = {1'b0, p64} + 65'h80000000;
  assign rsum16 = {1'b0, p64} + 65'h8000;
  assign rnd32  = rsum32[63:32];
  assign r16_49 = {1'b0, rsum16[63:16]};
  assign wx49   = {{17{wx[31]}}, wx};
  assign wy49   = {{17{wy[31]}}, wy};

  // final rotation rounding and accumulate
  assign rsumx = {1'b0, magx} + 65'h20000000;
  assign rsumy = {1'b0, magy} + 65'h20000000;
  assign rx50  = {16'b0, rsumx[63:30]};
  assign ry50  = {16'b0, rsumy[63:30]};
  assign ax50  = {{2{acc_x[47]}}, acc_x};
  assign ay50  = {{2{acc_y[47]}}, acc_y};

  // display wrap from the reduced angle
  assign rem_s = {1'b0, mod_rem};
  always_comb begin
    if (ng > HALF33)
      disp_next = (mod_rem > HALF_TURN) ? 25'(rem_s - FULL_S) : 25'(rem_s);
    else if (ng < -HALF33)
      disp_next = (mod_rem >= HALF_TURN) ? 25'(rem_s - FULL_S) : 25'(rem_s);
    else
      disp_next = ng[24:0];
  end

  // unit starts
  assign mul_start = (state == S_LAUNCH) && !mul_st.busy && !((op == OP_AC) && !cordic_ok);
  assign mod_start = in_acc || (state == S_RND);
  assign mod_val   = (state == S_RND) ? ng : {heading_now[31], heading_now};
  assign cor_start = mod_st.done && !mod_disp;

  odo_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mcand),
    .mplier (mplier),
    .prod   (mul_prod),
    .stat   (mul_st)
  );

  odo_modr u_modr (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .val   (mod_val),
    .rem   (mod_rem),
    .stat  (mod_st)
  );

  odo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (mod_rem),
    .cos_o (cos_v),
    .sin_o (sin_v),
    .stat  (cor_st)
  );

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_TX;
      mod_disp     <= 1'b0;
      cordic_ok    <= 1'b0;
      out_valid    <= 1'b0;
      acc_x        <= '0;
      acc_y        <= '0;
      heading_now  <= '0;
      heading_prev <= '0;
    end else begin
      if (cor_st.done) cordic_ok <= 1'b1;
      if ((state == S_OUT) && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state     <= S_LAUNCH;
            op        <= OP_TX;
            mod_disp  <= 1'b0;
            cordic_ok <= 1'b0;
          end
        end
        S_LAUNCH: begin
          if (mul_start) state <= S_MULW;
        end
        S_MULW: begin
          if (mul_st.done) begin
            if (op == OP_AS) begin
              state <= S_RND;
            end else begin
              op    <= op_t'(op + 4'd1);
              state <= S_LAUNCH;
            end
          end
        end
        S_RND: begin
          mod_disp     <= 1'b1;
          heading_prev <= heading_now;
          heading_now  <= ng[31:0];
          state        <= S_ACC;
        end
        S_ACC: begin
          acc_x <= clamp48(negx ? (ax50 - rx50) : (ax50 + rx50));
          acc_y <= clamp48(negy ? (ay50 - ry50) : (ay50 + ry50));
          state <= S_DISPW;
        end
        S_DISPW: begin
          if (mod_st.done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_neg <= (count_x >= NEG_COUNT);
      cy_neg <= (count_y >= NEG_COUNT);
      cx_mag <= (count_x >= NEG_COUNT) ? (~count_x + 16'd1) : count_x;
      cy_mag <= (count_y >= NEG_COUNT) ? (~count_y + 16'd1) : count_y;
      g_q    <= gyro_heading;
      dh_neg <= dh[32];
      dh_mag <= dh[32] ? (~dh + 33'd1) : dh;
    end
    if ((state == S_MULW) && mul_st.done) begin
      case (op)
        OP_TX, OP_TY: tprod <= mul_prod[33:0];
        OP_WX: wx  <= mul_sgn ? (~rnd32 + 32'd1) : rnd32;
        OP_WY: wy  <= mul_sgn ? (~rnd32 + 32'd1) : rnd32;
        OP_DT: dth <= mul_sgn ? (~rnd32 + 32'd1) : rnd32;
        OP_LA: a_q <= clamp32(mul_sgn ? (wx49 + r16_49) : (wx49 - r16_49));
        OP_LB: b_q <= clamp32(mul_sgn ? (wy49 + r16_49) : (wy49 - r16_49));
        OP_AC: sumx <= mul_sgn ? (64'sd0 - p_s) : p_s;
        OP_BS: sumx <= mul_sgn ? (sumx + p_s) : (sumx - p_s);
        OP_BC: sumy <= mul_sgn ? (64'sd0 - p_s) : p_s;
        OP_AS: sumy <= mul_sgn ? (sumy - p_s) : (sumy + p_s);
        default: ;
      endcase
    end
    if (state == S_RND) begin
      negx <= sumx[63];
      negy <= sumy[63];
      magx <= sumx[63] ? (~sumx + 64'd1) : sumx;
      magy <= sumy[63] ? (~sumy + 64'd1) : sumy;
    end
    if ((state == S_DISPW) && mod_st.done) disp_q <= disp_next;
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      pos_x         <= acc_x;
      pos_y         <= acc_y;
      display_angle <= disp_q;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/odo_check.sv */
`default_nettype none
module odo_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] pos_x,
  input logic signed [47:0] pos_y,
  input logic signed [24:0] display_angle
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(display_angle))
    else $error("stalled result changed");

  // one request in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // display angle stays within half a turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (display_angle >= -25'sd11796480) && (display_angle <= 25'sd11796480))
    else $error("display angle out of range");

  // reset leaves the block idle and empty
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind two_wheel_odometry_tracker_unit odo_check u_odo_check (.*);
`default_nettype wire
